// ----- rtl/rpa_pkg.sv -----
package rpa_pkg;

   localparam int NUM_PAGES  = 32768;
   localparam int PAGE_SIZE  = 4096;
   localparam int PAGE_BITS  = $clog2(PAGE_SIZE);

   localparam int ADDR_W     = 32;
   localparam int PAGE_W     = ADDR_W - PAGE_BITS;
   localparam int BASE_W     = 20;
   localparam int TOP_W      = 21;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 21;
   localparam int REF_W      = 8;

   localparam int SLOT_W     = $clog2(NUM_PAGES);
   localparam int CNT_W      = $clog2(NUM_PAGES + 1);
   // wide enough for page numbers, both bounds and their difference
   localparam int CMP_W      = ((PAGE_W > TOP_W) ? PAGE_W : TOP_W) + 2;

   localparam logic [REF_W-1:0]  REF_MAX        = {REF_W{1'b1}};
   localparam logic [BASE_W-1:0] BASE_RESET     = BASE_W'(524288);
   localparam logic [TOP_W-1:0]  TOP_RESET      = TOP_W'(557056);

   localparam logic [CSR_IDX_W-1:0] REG_BASE_PAGE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_TOP_PAGE  = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      FN_ALLOC   = 2'd0,
      FN_FREE    = 2'd1,
      FN_ADDREF  = 2'd2,
      FN_REBUILD = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_BAD_ADDR = 2'd2,
      ST_ZERO     = 2'd3
   } status_type;

   typedef enum logic {
      CS_IDLE,
      CS_EXEC
   } ctl_state_type;

   typedef struct packed {
      logic              rd;
      logic              pop;
      logic              push;
      logic [SLOT_W-1:0] push_slot;
      logic              rebuild;
      logic [CNT_W-1:0]  rebuild_n;
   } stk_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [SLOT_W-1:0] rd_slot;
   } stk_stat_type;

   typedef struct packed {
      logic              rd;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr;
      logic [SLOT_W-1:0] wr_addr;
      logic [REF_W-1:0]  wr_data;
      logic              clear;
   } cnt_cmd_type;

   typedef struct packed {
      logic [REF_W-1:0] rd_data;
      logic             busy;
   } cnt_stat_type;

endpackage

// ----- rtl/rpa_req_if.sv -----
interface rpa_req_if;
   import rpa_pkg::*;

   logic              valid;
   logic              ready;
   func_type          func;
   logic [ADDR_W-1:0] phys_addr;

   modport source (output valid, output func, output phys_addr, input ready);
   modport sink   (input valid, input func, input phys_addr, output ready);
endinterface

// ----- rtl/rpa_rsp_if.sv -----
interface rpa_rsp_if;
   import rpa_pkg::*;

   logic              valid;
   logic              ready;
   status_type        status;
   logic [ADDR_W-1:0] page_addr;
   logic [REF_W-1:0]  ref_count;
   logic              released;

   modport source (output valid, output status, output page_addr, output ref_count,
                   output released, input ready);
   modport sink   (input valid, input status, input page_addr, input ref_count,
                   input released, output ready);
endinterface

// ----- rtl/rpa_stack.sv -----
module rpa_stack (
   input  logic                 clock,
   input  logic                 reset,
   input  rpa_pkg::stk_cmd_type cmd,
   output rpa_pkg::stk_stat_type stat
);
   import rpa_pkg::*;

   logic [SLOT_W-1:0] stack_mem [NUM_PAGES];
   logic [SLOT_W-1:0] rd_mem_ff;
   logic              rd_ident_ff;
   logic [SLOT_W-1:0] rd_pos_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   // entries below the low mark still hold their rebuild value, the slot equal to the position
   logic [CNT_W-1:0] low_ff, low_in;
   logic [CNT_W-1:0] top_pos;

   assign top_pos = count_ff - CNT_W'(1);

   always_comb begin
      count_in = count_ff;
      low_in   = low_ff;
      if (cmd.rebuild) begin
         count_in = cmd.rebuild_n;
         low_in   = CNT_W'(NUM_PAGES);
      end else if (cmd.pop) begin
         count_in = top_pos;
      end else if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
         if (count_ff < low_ff) begin
            low_in = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         low_ff   <= '0;
      end else begin
         count_ff <= count_in;
         low_ff   <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[count_ff[SLOT_W-1:0]] <= cmd.push_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_mem_ff   <= stack_mem[top_pos[SLOT_W-1:0]];
         rd_ident_ff <= top_pos < low_ff;
         rd_pos_ff   <= top_pos[SLOT_W-1:0];
      end
   end

   assign stat.count   = count_ff;
   assign stat.rd_slot = rd_ident_ff ? rd_pos_ff : rd_mem_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NUM_PAGES))
      else $error("free stack count above capacity");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop || cmd.rd) |-> count_ff != '0)
      else $error("pop or read of an empty free stack");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> count_ff != CNT_W'(NUM_PAGES))
      else $error("push onto a full free stack");

endmodule

// ----- rtl/rpa_counts.sv -----
module rpa_counts (
   input  logic                 clock,
   input  logic                 reset,
   input  rpa_pkg::cnt_cmd_type cmd,
   output rpa_pkg::cnt_stat_type stat
);
   import rpa_pkg::*;

   logic [REF_W-1:0]  count_mem [NUM_PAGES];
   logic [REF_W-1:0]  rd_mem_ff;

   logic              busy_ff, busy_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [REF_W-1:0]  wr_data;

   always_comb begin
      busy_in = busy_ff;
      ptr_in  = ptr_ff;
      if (cmd.clear) begin
         busy_in = 1'b1;
         ptr_in  = '0;
      end else if (busy_ff) begin
         if (ptr_ff == SLOT_W'(NUM_PAGES - 1)) begin
            busy_in = 1'b0;
         end else begin
            ptr_in = ptr_ff + SLOT_W'(1);
         end
      end
   end

   // clearing sweep owns the write port while it runs
   assign wr_en   = busy_ff || cmd.wr;
   assign wr_addr = busy_ff ? ptr_ff : cmd.wr_addr;
   assign wr_data = busy_ff ? '0 : cmd.wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         ptr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         ptr_ff  <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_mem_ff <= count_mem[cmd.rd_addr];
      end
   end

   assign stat.rd_data = rd_mem_ff;
   assign stat.busy    = busy_ff;

endmodule

// ----- rtl/rpa_ctrl.sv -----
module rpa_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   rpa_req_if.sink                    req_chan,
   rpa_rsp_if.source                  rsp_chan,
   input  logic                       csr_we,
   input  logic [rpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rpa_pkg::stk_cmd_type       stk_cmd,
   input  rpa_pkg::stk_stat_type      stk_stat,
   output rpa_pkg::cnt_cmd_type       cnt_cmd,
   input  rpa_pkg::cnt_stat_type      cnt_stat
);
   import rpa_pkg::*;

   ctl_state_type state_ff, state_in;

   logic [BASE_W-1:0] base_ff, base_in;
   logic [TOP_W-1:0]  top_ff, top_in;

   func_type          func_ff, func_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              bad_ff, bad_in;
   logic              empty_ff, empty_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_page_addr_ff, rsp_page_addr_in;
   logic [REF_W-1:0]  rsp_ref_count_ff, rsp_ref_count_in;
   logic              rsp_released_ff, rsp_released_in;

   logic              accept;
   logic              out_free;

   // address check on the incoming request
   logic [CMP_W-1:0]  page_ext, base_ext, top_ext, page_diff, bound_diff;
   logic              addr_ok;
   logic [CNT_W-1:0]  rebuild_n;

   logic [REF_W-1:0]  cur_count, dec_count, inc_count;
   logic [ADDR_W-1:0] alloc_addr;

   assign page_ext   = CMP_W'(req_chan.phys_addr[ADDR_W-1:PAGE_BITS]);
   assign base_ext   = CMP_W'(base_ff);
   assign top_ext    = CMP_W'(top_ff);
   assign page_diff  = page_ext - base_ext;
   assign bound_diff = top_ext - base_ext;

   assign addr_ok = (req_chan.phys_addr[PAGE_BITS-1:0] == '0) && (page_ext >= base_ext)
                 && (page_ext < top_ext) && (page_diff < CMP_W'(NUM_PAGES));

   always_comb begin
      if (top_ext <= base_ext) begin
         rebuild_n = '0;
      end else if (bound_diff > CMP_W'(NUM_PAGES)) begin
         rebuild_n = CNT_W'(NUM_PAGES);
      end else begin
         rebuild_n = bound_diff[CNT_W-1:0];
      end
   end

   assign cur_count  = cnt_stat.rd_data;
   assign dec_count  = cur_count - REF_W'(1);
   assign inc_count  = (cur_count == REF_MAX) ? cur_count : cur_count + REF_W'(1);
   assign alloc_addr = (ADDR_W'(base_ff) + ADDR_W'(stk_stat.rd_slot)) << PAGE_BITS;

   assign req_chan.ready = (state_ff == CS_IDLE) && !cnt_stat.busy;
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      base_in = base_ff;
      top_in  = top_ff;
      if (csr_we) begin
         case (csr_index)
            REG_BASE_PAGE: base_in = csr_wdata[BASE_W-1:0];
            REG_TOP_PAGE:  top_in  = csr_wdata[TOP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in         = state_ff;
      func_in          = func_ff;
      slot_in          = slot_ff;
      bad_in           = bad_ff;
      empty_in         = empty_ff;
      stk_cmd          = '0;
      cnt_cmd          = '0;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in    = rsp_status_ff;
      rsp_page_addr_in = rsp_page_addr_ff;
      rsp_ref_count_in = rsp_ref_count_ff;
      rsp_released_in  = rsp_released_ff;

      case (state_ff)
         CS_IDLE: begin
            if (accept) begin
               func_in  = req_chan.func;
               slot_in  = page_diff[SLOT_W-1:0];
               bad_in   = !addr_ok;
               empty_in = stk_stat.count == '0;
               state_in = CS_EXEC;
               case (req_chan.func)
                  FN_ALLOC: begin
                     stk_cmd.rd = stk_stat.count != '0;
                  end
                  FN_FREE, FN_ADDREF: begin
                     cnt_cmd.rd      = addr_ok;
                     cnt_cmd.rd_addr = page_diff[SLOT_W-1:0];
                  end
                  FN_REBUILD: begin
                     stk_cmd.rebuild   = 1'b1;
                     stk_cmd.rebuild_n = rebuild_n;
                     cnt_cmd.clear     = 1'b1;
                  end
                  default: ;
               endcase
            end
         end

         CS_EXEC: begin
            // rebuild answers once the count sweep has finished
            if (out_free && !(func_ff == FN_REBUILD && cnt_stat.busy)) begin
               state_in         = CS_IDLE;
               rsp_valid_in     = 1'b1;
               rsp_status_in    = ST_OK;
               rsp_page_addr_in = '0;
               rsp_ref_count_in = '0;
               rsp_released_in  = 1'b0;
               case (func_ff)
                  FN_ALLOC: begin
                     if (empty_ff) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        stk_cmd.pop      = 1'b1;
                        cnt_cmd.wr       = 1'b1;
                        cnt_cmd.wr_addr  = stk_stat.rd_slot;
                        cnt_cmd.wr_data  = REF_W'(1);
                        rsp_page_addr_in = alloc_addr;
                        rsp_ref_count_in = REF_W'(1);
                     end
                  end
                  FN_FREE: begin
                     if (bad_ff) begin
                        rsp_status_in = ST_BAD_ADDR;
                     end else if (cur_count == '0) begin
                        rsp_status_in = ST_ZERO;
                     end else begin
                        cnt_cmd.wr       = 1'b1;
                        cnt_cmd.wr_addr  = slot_ff;
                        cnt_cmd.wr_data  = dec_count;
                        rsp_ref_count_in = dec_count;
                        if (dec_count == '0 && stk_stat.count != CNT_W'(NUM_PAGES)) begin
                           stk_cmd.push      = 1'b1;
                           stk_cmd.push_slot = slot_ff;
                           rsp_released_in   = 1'b1;
                        end
                     end
                  end
                  FN_ADDREF: begin
                     if (bad_ff) begin
                        rsp_status_in = ST_BAD_ADDR;
                     end else begin
                        cnt_cmd.wr       = 1'b1;
                        cnt_cmd.wr_addr  = slot_ff;
                        cnt_cmd.wr_data  = inc_count;
                        rsp_ref_count_in = inc_count;
                     end
                  end
                  FN_REBUILD: ;
                  default: ;
               endcase
            end
         end

         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= BASE_RESET;
         top_ff       <= TOP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         top_ff       <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff          <= func_in;
      slot_ff          <= slot_in;
      bad_ff           <= bad_in;
      empty_ff         <= empty_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_page_addr_ff <= rsp_page_addr_in;
      rsp_ref_count_ff <= rsp_ref_count_in;
      rsp_released_ff  <= rsp_released_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.page_addr = rsp_page_addr_ff;
   assign rsp_chan.ref_count = rsp_ref_count_ff;
   assign rsp_chan.released  = rsp_released_ff;

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      cnt_stat.busy |-> !req_chan.ready)
      else $error("request taken during count clearing");

   a_released_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_released_ff) |->
         (rsp_status_ff == ST_OK && rsp_ref_count_ff == '0))
      else $error("released page with nonzero count or error status");

   a_rebuild_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_EXEC && func_ff == FN_REBUILD && cnt_stat.busy) |=>
         state_ff == CS_EXEC)
      else $error("rebuild answered before count clearing finished");

endmodule

// ----- rtl/refcounted_page_allocator_top.sv -----
// Reference-counted page allocator.
// req_chan carries one request (func, phys_addr); rsp_chan returns exactly one
// response per request, in order. csr_we/csr_index/csr_wdata write base_page
// (index 0) and top_page (index 1); write them only while no request is open.
// Alloc, free and add reference pass through the states IDLE and EXEC: IDLE
// accepts the request and starts the synchronous read of the free stack or
// count memory; EXEC does the update and write back and loads the response
// register. Rebuild resets the stack top directly but clears every reference
// count with a sweep of the count memory, one entry per cycle, and answers
// once the sweep has finished. After reset the same sweep runs with
// req_chan.ready low; the stack starts empty, so a rebuild is the usual first
// request.
// A response held by a stalled receiver does not block the next request: it is
// accepted and read, and its update waits until the response register frees.
module refcounted_page_allocator_top (
   input  logic                           clock,
   input  logic                           reset,
   rpa_req_if.sink                        req_chan,
   rpa_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [rpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rpa_pkg::*;

   stk_cmd_type  stk_cmd;
   stk_stat_type stk_stat;
   cnt_cmd_type  cnt_cmd;
   cnt_stat_type cnt_stat;

   rpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stk_cmd   (stk_cmd),
      .stk_stat  (stk_stat),
      .cnt_cmd   (cnt_cmd),
      .cnt_stat  (cnt_stat)
   );

   rpa_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .stat  (stk_stat)
   );

   rpa_counts u_counts (
      .clock (clock),
      .reset (reset),
      .cmd   (cnt_cmd),
      .stat  (cnt_stat)
   );

endmodule
